// ===== rtl/lcr_pkg.sv =====
// Shared types and constants for the line and circle rasterizer.
package lcr_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int MAX_RESULTS    = 8;
  localparam int CFG_IDX_BITS   = 2;

  localparam int CANVAS_W_RESET = 640;
  localparam int CANVAS_H_RESET = 480;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_LINE   = 2'd1,
    MODE_CIRCLE = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ACT_LINE   = 2'd0,
    ACT_CIRCLE = 2'd1,
    ACT_STEP   = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CANVAS_WIDTH  = 2'd0,
    CFG_CANVAS_HEIGHT = 2'd1
  } cfg_reg_t;

endpackage

// ===== rtl/line_and_circle_rasterizer.sv =====
// Bresenham line and midpoint circle rasterizer with a pixel output queue.
//
// Input channel (in_valid/in_ready) takes command words: start a line from
// point A to point B, start a circle centred at A, or advance one step.
// A start that falls outside the canvas gives one word with out_rejected set;
// an accepted start gives nothing. Each advance gives one pixel of a line, or
// four (first advance) or eight pixels of a circle; the final pixel of a
// primitive carries out_last_pixel. A new start drops the primitive in flight.
// The step logic sits between the primitive state registers and an 8-deep
// result queue, so results appear in the cycle after the input word is taken.
// The output drains one word per cycle while out_ready is high; the input is
// ready while the queue is empty or its final word leaves in this cycle. Line
// advances sustain one word per cycle while out_ready is high.
// cfg_we writes canvas_width (index 0) or canvas_height (index 1); write
// only while idle. Synchronous active-low reset empties the queue, idles the
// block and sets the canvas to 640 by 480. A stalled receiver holds the
// head word, and the input stays held off while any word waits in the queue.
module line_and_circle_rasterizer #(
  parameter int COORD_BITS = lcr_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lcr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [COORD_BITS:0]               cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_action,
  input  logic [COORD_BITS-1:0]             in_point_a_x,
  input  logic [COORD_BITS-1:0]             in_point_a_y,
  input  logic [COORD_BITS-1:0]             in_point_b_x,
  input  logic [COORD_BITS-1:0]             in_point_b_y,
  input  logic [COORD_BITS-2:0]             in_circle_radius,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [COORD_BITS-1:0]             out_pixel_x,
  output logic [COORD_BITS-1:0]             out_pixel_y,
  output logic                              out_last_pixel,
  output logic                              out_rejected
);
  import lcr_pkg::*;

  localparam int CW   = COORD_BITS;
  localparam int DW   = CW + 1;
  localparam int EW   = CW + 2;
  localparam int SW   = CW + 2;
  localparam int DCW  = CW + 4;
  localparam int NR   = MAX_RESULTS;
  localparam int CNTW = $clog2(NR + 1);

  // configuration
  logic [DW-1:0] canvas_w_r, canvas_h_r;

  // primitive state
  mode_t           mode_r, mode_nxt;
  logic            first_r, first_nxt;
  logic [CW-1:0]   cur_x_r, cur_y_r, cur_x_nxt, cur_y_nxt;
  logic [CW-1:0]   tgt_x_r, tgt_y_r, tgt_x_nxt, tgt_y_nxt;
  logic [CW-1:0]   dx_r, dy_r, dx_nxt, dy_nxt;
  logic            sxn_r, syn_r, sxn_nxt, syn_nxt;
  logic [EW-1:0]   err_r, err_nxt;
  logic [CW-1:0]   min_r, maj_r, min_nxt, maj_nxt;
  logic [DCW-1:0]  dec_r, dec_nxt;
  logic [SW-1:0]   dsx_r, dsy_r, dsx_nxt, dsy_nxt;

  // result queue, head at entry 0
  logic [CW-1:0]   qx_r [NR];
  logic [CW-1:0]   qy_r [NR];
  logic            ql_r [NR];
  logic            qj_r [NR];
  logic [CNTW-1:0] cnt_r;

  logic [CW-1:0]   res_x [NR];
  logic [CW-1:0]   res_y [NR];
  logic            res_l [NR];
  logic            res_j [NR];
  logic [CNTW-1:0] nres;

  logic in_acc, pop;
  logic line_rej, circ_rej, line_done, circ_last;

  // helpers
  logic [DW-1:0]   ax_sum, ay_sum;
  logic [CW-1:0]   abs_dx, abs_dy;
  logic [EW:0]     e2;
  logic            e2_gt, e2_lt;
  logic            dec_ge0;
  logic [CW-1:0]   maj_s, min_s;
  logic [SW-1:0]   dsy_s, dsx_s;
  logic [DCW-1:0]  dec_a;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign in_ready  = (cnt_r == '0) || ((cnt_r == CNTW'(1)) && out_ready);
  assign in_acc    = in_valid && in_ready;

  assign out_pixel_x    = qx_r[0];
  assign out_pixel_y    = qy_r[0];
  assign out_last_pixel = ql_r[0];
  assign out_rejected   = qj_r[0];

  // start checks
  assign ax_sum   = {1'b0, in_point_a_x} + DW'(in_circle_radius);
  assign ay_sum   = {1'b0, in_point_a_y} + DW'(in_circle_radius);
  assign line_rej = !({1'b0, in_point_a_x} < canvas_w_r) || !({1'b0, in_point_a_y} < canvas_h_r)
                 || !({1'b0, in_point_b_x} < canvas_w_r) || !({1'b0, in_point_b_y} < canvas_h_r);
  assign circ_rej = (in_point_a_x < CW'(in_circle_radius)) || (in_point_a_y < CW'(in_circle_radius))
                 || !(ax_sum < canvas_w_r) || !(ay_sum < canvas_h_r);

  assign abs_dx = (in_point_a_x > in_point_b_x) ? in_point_a_x - in_point_b_x
                                                : in_point_b_x - in_point_a_x;
  assign abs_dy = (in_point_a_y > in_point_b_y) ? in_point_a_y - in_point_b_y
                                                : in_point_b_y - in_point_a_y;

  // line step
  assign line_done = (cur_x_r == tgt_x_r) && (cur_y_r == tgt_y_r);
  assign e2    = {err_r, 1'b0};
  assign e2_gt = $signed(e2) > $signed((EW+1)'(0) - (EW+1)'(dy_r));
  assign e2_lt = $signed(e2) < $signed((EW+1)'(dx_r));

  // circle step: midpoint update before the octant points
  assign dec_ge0 = !dec_r[DCW-1];
  assign maj_s   = dec_ge0 ? maj_r - CW'(1) : maj_r;
  assign dsy_s   = dec_ge0 ? dsy_r + SW'(2) : dsy_r;
  assign dec_a   = dec_ge0 ? dec_r + {{(DCW-SW){dsy_s[SW-1]}}, dsy_s} : dec_r;
  assign min_s   = min_r + CW'(1);
  assign dsx_s   = dsx_r + SW'(2);
  assign circ_last = first_r ? !(min_r < maj_r) : !(min_s < maj_s);

  // next mode
  always_comb begin
    mode_nxt = mode_r;
    if (in_acc) begin
      unique case (in_action)
        ACT_LINE:   mode_nxt = line_rej ? MODE_IDLE : MODE_LINE;
        ACT_CIRCLE: mode_nxt = circ_rej ? MODE_IDLE : MODE_CIRCLE;
        ACT_STEP: begin
          unique case (mode_r)
            MODE_LINE:   if (line_done) mode_nxt = MODE_IDLE;
            MODE_CIRCLE: if (circ_last) mode_nxt = MODE_IDLE;
            default:     mode_nxt = mode_r;
          endcase
        end
        default: mode_nxt = mode_r;
      endcase
    end
  end

  // datapath and result words
  always_comb begin
    first_nxt = first_r;
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    tgt_x_nxt = tgt_x_r;
    tgt_y_nxt = tgt_y_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    sxn_nxt   = sxn_r;
    syn_nxt   = syn_r;
    err_nxt   = err_r;
    min_nxt   = min_r;
    maj_nxt   = maj_r;
    dec_nxt   = dec_r;
    dsx_nxt   = dsx_r;
    dsy_nxt   = dsy_r;
    nres      = '0;
    for (int i = 0; i < NR; i++) begin
      res_x[i] = '0;
      res_y[i] = '0;
      res_l[i] = 1'b0;
      res_j[i] = 1'b0;
    end
    unique case (in_action)
      ACT_LINE: begin
        if (line_rej) begin
          res_j[0] = 1'b1;
          nres     = CNTW'(1);
        end else begin
          cur_x_nxt = in_point_a_x;
          cur_y_nxt = in_point_a_y;
          tgt_x_nxt = in_point_b_x;
          tgt_y_nxt = in_point_b_y;
          dx_nxt    = abs_dx;
          dy_nxt    = abs_dy;
          sxn_nxt   = !(in_point_a_x < in_point_b_x);
          syn_nxt   = !(in_point_a_y < in_point_b_y);
          err_nxt   = EW'(abs_dx) - EW'(abs_dy);
        end
      end
      ACT_CIRCLE: begin
        if (circ_rej) begin
          res_j[0] = 1'b1;
          nres     = CNTW'(1);
        end else begin
          cur_x_nxt = in_point_a_x;
          cur_y_nxt = in_point_a_y;
          min_nxt   = '0;
          maj_nxt   = CW'(in_circle_radius);
          dec_nxt   = DCW'(1) - DCW'(in_circle_radius);
          dsx_nxt   = SW'(1);
          dsy_nxt   = SW'(0) - {2'b00, in_circle_radius, 1'b0};
          first_nxt = 1'b1;
        end
      end
      ACT_STEP: begin
        unique case (mode_r)
          MODE_LINE: begin
            res_x[0] = cur_x_r;
            res_y[0] = cur_y_r;
            res_l[0] = line_done;
            nres     = CNTW'(1);
            if (!line_done) begin
              err_nxt = err_r - (e2_gt ? EW'(dy_r) : EW'(0))
                              + (e2_lt ? EW'(dx_r) : EW'(0));
              if (e2_gt) cur_x_nxt = sxn_r ? cur_x_r - CW'(1) : cur_x_r + CW'(1);
              if (e2_lt) cur_y_nxt = syn_r ? cur_y_r - CW'(1) : cur_y_r + CW'(1);
            end
          end
          MODE_CIRCLE: begin
            if (first_r) begin
              first_nxt = 1'b0;
              res_x[0] = cur_x_r;          res_y[0] = cur_y_r + maj_r;
              res_x[1] = cur_x_r;          res_y[1] = cur_y_r - maj_r;
              res_x[2] = cur_x_r + maj_r;  res_y[2] = cur_y_r;
              res_x[3] = cur_x_r - maj_r;  res_y[3] = cur_y_r;
              res_l[3] = circ_last;
              nres     = CNTW'(4);
            end else begin
              maj_nxt = maj_s;
              min_nxt = min_s;
              dsy_nxt = dsy_s;
              dsx_nxt = dsx_s;
              dec_nxt = dec_a + {{(DCW-SW){dsx_s[SW-1]}}, dsx_s};
              res_x[0] = cur_x_r + min_s;  res_y[0] = cur_y_r + maj_s;
              res_x[1] = cur_x_r - min_s;  res_y[1] = cur_y_r + maj_s;
              res_x[2] = cur_x_r + min_s;  res_y[2] = cur_y_r - maj_s;
              res_x[3] = cur_x_r - min_s;  res_y[3] = cur_y_r - maj_s;
              res_x[4] = cur_x_r + maj_s;  res_y[4] = cur_y_r + min_s;
              res_x[5] = cur_x_r - maj_s;  res_y[5] = cur_y_r + min_s;
              res_x[6] = cur_x_r + maj_s;  res_y[6] = cur_y_r - min_s;
              res_x[7] = cur_x_r - maj_s;  res_y[7] = cur_y_r - min_s;
              res_l[7] = circ_last;
              nres     = CNTW'(8);
            end
          end
          default: nres = '0;
        endcase
      end
      default: nres = '0;
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      first_r    <= 1'b0;
      cnt_r      <= '0;
      canvas_w_r <= DW'(CANVAS_W_RESET);
      canvas_h_r <= DW'(CANVAS_H_RESET);
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_CANVAS_WIDTH)  canvas_w_r <= cfg_wdata;
        if (cfg_index == CFG_CANVAS_HEIGHT) canvas_h_r <= cfg_wdata;
      end
      if (in_acc) begin
        mode_r  <= mode_nxt;
        first_r <= first_nxt;
        cnt_r   <= nres;
      end else if (pop) begin
        cnt_r <= cnt_r - CNTW'(1);
      end
    end
  end

  // primitive payload and result queue
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      tgt_x_r <= tgt_x_nxt;
      tgt_y_r <= tgt_y_nxt;
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
      sxn_r   <= sxn_nxt;
      syn_r   <= syn_nxt;
      err_r   <= err_nxt;
      min_r   <= min_nxt;
      maj_r   <= maj_nxt;
      dec_r   <= dec_nxt;
      dsx_r   <= dsx_nxt;
      dsy_r   <= dsy_nxt;
      for (int i = 0; i < NR; i++) begin
        qx_r[i] <= res_x[i];
        qy_r[i] <= res_y[i];
        ql_r[i] <= res_l[i];
        qj_r[i] <= res_j[i];
      end
    end else if (pop) begin
      // advance the queue toward the head
      for (int i = 0; i < NR - 1; i++) begin
        qx_r[i] <= qx_r[i+1];
        qy_r[i] <= qy_r[i+1];
        ql_r[i] <= ql_r[i+1];
        qj_r[i] <= qj_r[i+1];
      end
    end
  end

`ifndef SYNTH
  a_accept_drains: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ((cnt_r == '0) || pop))
    else $error("input word taken while queued results remain");

  a_reject_one: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (((in_action == ACT_LINE) && line_rej) ||
                ((in_action == ACT_CIRCLE) && circ_rej)))
    |=> ((cnt_r == CNTW'(1)) && out_rejected && (mode_r == MODE_IDLE)))
    else $error("refused start did not give a single rejected word");

  a_last_not_rejected: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_last_pixel && out_rejected))
    else $error("word marked both last and rejected");

  a_last_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_action == ACT_STEP) && (mode_r == MODE_LINE) && line_done)
    |=> (mode_r == MODE_IDLE))
    else $error("line did not idle after its end point");
`endif

endmodule
